### design/smvci_pkg.sv
// Shared types, widths and constants for the sample statistics block.
`default_nettype none
package smvci_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int VAR_W      = 47;
    localparam int SE_W       = 24;
    localparam int CI_W       = 26;
    localparam int CNT_OUT_W  = 15;
    localparam int STAT_W     = 2;
    localparam int SUM_W      = 40;
    localparam int SQ_W       = 63;
    localparam int WIDE_W     = 80;
    localparam int DIVR_W     = 32;
    localparam int MUL_B_W    = 40;
    localparam int MUL_STEPS  = 40;
    localparam int DIV_STEPS  = 80;
    localparam int SQRT_STEPS = 24;
    localparam int STEP_CNT_W = 7;
    localparam int OUT_DATA_W = 168;

    localparam int DEF_MAX_SAMPLES = 16384;
    localparam int DEF_SAMPLE_BITS = 24;

    // 1.96 as 196/100; the division by 100 is a multiplication by the rounded-up
    // reciprocal 2^37/100 followed by a 37-bit shift, exact for any 32-bit dividend.
    localparam int          CI_SCALE_NUM = 196;
    localparam logic [31:0] CI_DEN_RECIP = 32'h51EB_851F;
    localparam int          CI_DEN_SHIFT = 37;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STAT_W-1:0] ST_SINGLE  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DROPPED = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_SNAP,
        OP_MUL_A_LD,
        OP_MUL_STEP,
        OP_MUL_B_LD,
        OP_NUM,
        OP_DIV_STEP,
        OP_VAR_LD,
        OP_SQRT_LD,
        OP_SQRT_STEP,
        OP_MARGIN_LD,
        OP_MEAN_LD,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_cmd;

    typedef struct packed {
        logic special;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

### design/smvci_ctrl.sv
// Sequencing state machine for accumulation and the end-of-set arithmetic.
`default_nettype none
module smvci_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_last,
    output logic                 o_in_ready,
    input  smvci_pkg::t_status   i_status,
    output smvci_pkg::t_cmd      o_cmd
);
    import smvci_pkg::*;

    typedef enum logic [4:0] {
        S_ACC, S_SNAP, S_LDMA, S_RMA, S_LDMB, S_RMB, S_NUM, S_RDV,
        S_LDDQ, S_RDQ, S_LDSQ, S_RSQ, S_LDMG, S_LDMN, S_RMN, S_FIN
    } t_state;

    t_state                r_state, n_state;
    logic [STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic                  cnt_done;

    assign cnt_done   = (r_cnt == '0);
    assign o_in_ready = (r_state == S_ACC);

    always_comb begin
        o_cmd.accept = o_in_ready & i_in_valid;
        case (r_state)
            S_SNAP:  o_cmd.op = OP_SNAP;
            S_LDMA:  o_cmd.op = OP_MUL_A_LD;
            S_RMA:   o_cmd.op = OP_MUL_STEP;
            S_LDMB:  o_cmd.op = OP_MUL_B_LD;
            S_RMB:   o_cmd.op = OP_MUL_STEP;
            S_NUM:   o_cmd.op = OP_NUM;
            S_RDV:   o_cmd.op = OP_DIV_STEP;
            S_LDDQ:  o_cmd.op = OP_VAR_LD;
            S_RDQ:   o_cmd.op = OP_DIV_STEP;
            S_LDSQ:  o_cmd.op = OP_SQRT_LD;
            S_RSQ:   o_cmd.op = OP_SQRT_STEP;
            S_LDMG:  o_cmd.op = OP_MARGIN_LD;
            S_LDMN:  o_cmd.op = OP_MEAN_LD;
            S_RMN:   o_cmd.op = OP_DIV_STEP;
            S_FIN:   o_cmd.op = i_status.out_free ? OP_FINISH : OP_NONE;
            default: o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_ACC:  if (o_cmd.accept && i_in_last) n_state = S_SNAP;
            S_SNAP: n_state = i_status.special ? S_FIN : S_LDMA;
            S_LDMA: begin
                n_state = S_RMA;
                n_cnt   = STEP_CNT_W'(MUL_STEPS - 1);
            end
            S_RMA: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) n_state = S_LDMB;
            end
            S_LDMB: begin
                n_state = S_RMB;
                n_cnt   = STEP_CNT_W'(MUL_STEPS - 1);
            end
            S_RMB: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) n_state = S_NUM;
            end
            S_NUM: begin
                n_state = S_RDV;
                n_cnt   = STEP_CNT_W'(DIV_STEPS - 1);
            end
            S_RDV: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) n_state = S_LDDQ;
            end
            S_LDDQ: begin
                n_state = S_RDQ;
                n_cnt   = STEP_CNT_W'(DIV_STEPS - 1);
            end
            S_RDQ: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) n_state = S_LDSQ;
            end
            S_LDSQ: begin
                n_state = S_RSQ;
                n_cnt   = STEP_CNT_W'(SQRT_STEPS - 1);
            end
            S_RSQ: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) n_state = S_LDMG;
            end
            S_LDMG: n_state = S_LDMN;
            S_LDMN: begin
                n_state = S_RMN;
                n_cnt   = STEP_CNT_W'(DIV_STEPS - 1);
            end
            S_RMN: begin
                n_cnt = r_cnt - 1'b1;
                if (cnt_done) n_state = S_FIN;
            end
            S_FIN:  if (i_status.out_free) n_state = S_ACC;
            default: n_state = S_ACC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // A result is only loaded once the output register can take it.
    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_FINISH) |-> i_status.out_free)
        else $error("result loaded while output register busy");

    // The beat that closes a set stops intake until the result is formed.
    a_last_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accept && i_in_last) |=> !o_in_ready)
        else $error("samples taken after the closing beat");

    // The root iteration count stays within its step budget.
    a_sqrt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RSQ) |-> (r_cnt < STEP_CNT_W'(SQRT_STEPS)))
        else $error("root step counter out of range");

endmodule
`default_nettype wire

### design/smvci_dp.sv
// Accumulators, shared shift-add multiplier, divider, root unit and result register.
`default_nettype none
module smvci_dp #(
    parameter int MAX_SAMPLES = smvci_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = smvci_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  smvci_pkg::t_cmd                       i_cmd,
    output smvci_pkg::t_status                    o_status,
    input  wire                                   i_cfg_wr_en,
    input  wire                                   i_cfg_wr_data,
    input  wire  [smvci_pkg::SAMPLE_W-1:0]        i_sample,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic [smvci_pkg::SAMPLE_W-1:0]        o_mean,
    output logic [smvci_pkg::VAR_W-1:0]           o_var,
    output logic [smvci_pkg::SE_W-1:0]            o_se,
    output logic [smvci_pkg::CI_W-1:0]            o_ci_lo,
    output logic [smvci_pkg::CI_W-1:0]            o_ci_hi,
    output logic [smvci_pkg::CNT_OUT_W-1:0]       o_count,
    output logic [smvci_pkg::STAT_W-1:0]          o_stat
);
    import smvci_pkg::*;

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int SHIFT = SAMPLE_W - SAMPLE_BITS;
    localparam int RT_W  = 2 * SE_W;
    localparam int SR_W  = SE_W + 3;
    localparam int MX_W  = CI_W + 1;

    // Accumulators
    logic                    r_mode;
    logic signed [SUM_W-1:0] r_plain_sum, r_pair_sum;
    logic [SQ_W-1:0]         r_plain_sq, r_pair_sq;
    logic signed [SAMPLE_W-1:0] r_held;
    logic [CNT_W-1:0]        r_seen;
    logic                    r_ovf;

    // Snapshot of the closed set
    logic                    r_use_pair;
    logic [CNT_W-1:0]        r_m, r_n;
    logic signed [SUM_W-1:0] r_sum;
    logic [SQ_W-1:0]         r_sq;
    logic                    r_special;
    logic [STAT_W-1:0]       r_stat;

    // Arithmetic units
    logic [WIDE_W-1:0]       r_ma, r_macc, r_p1, r_dq;
    logic [MUL_B_W-1:0]      r_mb;
    logic [DIVR_W-1:0]       r_drem, r_dd;
    logic [VAR_W-1:0]        r_var;
    logic [RT_W-1:0]         r_sv;
    logic [SE_W-1:0]         r_root, r_se;
    logic [SR_W-1:0]         r_srem;
    logic [CI_W-1:0]         r_margin;

    logic signed [SAMPLE_W-1:0]   x_sh, x;
    logic signed [2*SAMPLE_W-1:0] x_sq;
    logic signed [SAMPLE_W:0]     pr;
    logic signed [2*SAMPLE_W+1:0] pr_sq;
    logic                    can_take, live_empty, live_single;
    logic [CNT_W-1:0]        live_m;
    logic [SUM_W-1:0]        sum_mag;
    logic [2*CNT_W-1:0]      mm;
    logic [DIVR_W-1:0]       den;
    logic [WIDE_W-1:0]       num;
    logic [DIVR_W:0]         d_cand;
    logic [DIVR_W+1:0]       d_diff;
    logic [SR_W+1:0]         s_cand;
    logic [SE_W+1:0]         s_trial;
    logic [SE_W+7:0]         se_scaled;
    logic [2*DIVR_W-1:0]     margin_prod;
    logic [SAMPLE_W:0]       q_adj;
    logic [SAMPLE_W-1:0]     mean;
    logic signed [MX_W-1:0]  mean_x, lo_x, hi_x, margin_x;
    logic [CI_W-1:0]         lo_s, hi_s;

    always_comb begin
        x_sh  = i_sample << SHIFT;
        x     = x_sh >>> SHIFT;
        x_sq  = x * x;
        pr    = (SAMPLE_W+1)'(r_held) + (SAMPLE_W+1)'(x);
        pr_sq = pr * pr;
        can_take = (r_seen < CNT_W'(MAX_SAMPLES));

        live_empty  = (r_seen == '0);
        live_single = (r_seen == CNT_W'(1)) || (r_mode && (r_seen == CNT_W'(2)));
        live_m      = (r_mode && !r_seen[0]) ? (r_seen >> 1) : r_seen;

        sum_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        mm      = r_m * (r_m - CNT_W'(1));
        den     = r_use_pair ? (DIVR_W'(mm) << 2) : DIVR_W'(mm);
        num     = (r_p1 < r_macc) ? '0 : (r_p1 - r_macc);

        d_cand  = {r_drem, r_dq[WIDE_W-1]};
        d_diff  = {1'b0, d_cand} - {2'b00, r_dd};

        s_cand  = {r_srem, r_sv[RT_W-1 -: 2]};
        s_trial = {r_root, 2'b01};

        se_scaled = r_root * (SE_W+8)'(CI_SCALE_NUM);
        // r_dq holds 196 times the standard error here; the product scales it by 1/100.
        margin_prod = (2*DIVR_W)'(r_dq[DIVR_W-1:0]) * (2*DIVR_W)'(CI_DEN_RECIP);

        q_adj = r_dq[SAMPLE_W:0] + (SAMPLE_W+1)'(r_drem != '0);
        mean  = r_sum[SUM_W-1] ? SAMPLE_W'(-q_adj) : r_dq[SAMPLE_W-1:0];
        mean_x   = MX_W'($signed(mean));
        margin_x = MX_W'({1'b0, r_margin});
        lo_x     = mean_x - margin_x;
        hi_x     = mean_x + margin_x;
        if (lo_x > MX_W'(2**(CI_W-1) - 1))   lo_s = CI_W'(2**(CI_W-1) - 1);
        else if (lo_x < -MX_W'(2**(CI_W-1))) lo_s = CI_W'(-(2**(CI_W-1)));
        else                                 lo_s = lo_x[CI_W-1:0];
        if (hi_x > MX_W'(2**(CI_W-1) - 1))   hi_s = CI_W'(2**(CI_W-1) - 1);
        else if (hi_x < -MX_W'(2**(CI_W-1))) hi_s = CI_W'(-(2**(CI_W-1)));
        else                                 hi_s = hi_x[CI_W-1:0];
    end

    assign o_status.special  = live_empty || live_single;
    assign o_status.out_free = !o_out_valid || i_out_ready;

    // Control state: configuration, accumulators and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_plain_sum <= '0;
            r_plain_sq  <= '0;
            r_pair_sum  <= '0;
            r_pair_sq   <= '0;
            r_held      <= '0;
            r_seen      <= '0;
            r_ovf       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_mode <= i_cfg_wr_data;
            if (i_cmd.accept) begin
                if (can_take) begin
                    r_plain_sum <= r_plain_sum + SUM_W'(x);
                    r_plain_sq  <= r_plain_sq + SQ_W'($unsigned(x_sq));
                    if (!r_seen[0]) begin
                        r_held <= x;
                    end else begin
                        r_pair_sum <= r_pair_sum + SUM_W'(pr);
                        r_pair_sq  <= r_pair_sq + SQ_W'($unsigned(pr_sq));
                    end
                    r_seen <= r_seen + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.op == OP_SNAP) begin
                r_plain_sum <= '0;
                r_plain_sq  <= '0;
                r_pair_sum  <= '0;
                r_pair_sq   <= '0;
                r_held      <= '0;
                r_seen      <= '0;
                r_ovf       <= 1'b0;
            end
            if (i_cmd.op == OP_FINISH)  o_out_valid <= 1'b1;
            else if (i_out_ready)       o_out_valid <= 1'b0;
        end
    end

    // Payload: snapshot, arithmetic units and result fields.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_SNAP: begin
                r_use_pair <= r_mode && !r_seen[0];
                r_m        <= live_m;
                r_n        <= r_seen;
                r_sum      <= (r_mode && !r_seen[0]) ? r_pair_sum : r_plain_sum;
                r_sq       <= (r_mode && !r_seen[0]) ? r_pair_sq : r_plain_sq;
                r_special  <= live_empty || live_single;
                if (live_empty)       r_stat <= ST_EMPTY;
                else if (live_single) r_stat <= ST_SINGLE;
                else if (r_ovf)       r_stat <= ST_DROPPED;
                else                  r_stat <= ST_OK;
            end
            OP_MUL_A_LD: begin
                r_ma   <= WIDE_W'(r_sq);
                r_mb   <= MUL_B_W'(r_m);
                r_macc <= '0;
            end
            OP_MUL_STEP: begin
                if (r_mb[0]) r_macc <= r_macc + r_ma;
                r_ma <= r_ma << 1;
                r_mb <= r_mb >> 1;
            end
            OP_MUL_B_LD: begin
                r_p1   <= r_macc;
                r_ma   <= WIDE_W'(sum_mag);
                r_mb   <= MUL_B_W'(sum_mag);
                r_macc <= '0;
            end
            OP_NUM: begin
                r_dq   <= num;
                r_drem <= '0;
                r_dd   <= den;
            end
            OP_DIV_STEP: begin
                if (!d_diff[DIVR_W+1]) begin
                    r_drem <= d_diff[DIVR_W-1:0];
                    r_dq   <= {r_dq[WIDE_W-2:0], 1'b1};
                end else begin
                    r_drem <= d_cand[DIVR_W-1:0];
                    r_dq   <= {r_dq[WIDE_W-2:0], 1'b0};
                end
            end
            OP_VAR_LD: begin
                // Quotients beyond the variance field saturate.
                if (r_dq[WIDE_W-1:VAR_W] != '0) begin
                    r_var <= '1;
                    r_dq  <= WIDE_W'({VAR_W{1'b1}});
                end else begin
                    r_var <= r_dq[VAR_W-1:0];
                    r_dq  <= WIDE_W'(r_dq[VAR_W-1:0]);
                end
                r_drem <= '0;
                r_dd   <= DIVR_W'(r_m);
            end
            OP_SQRT_LD: begin
                r_sv   <= RT_W'(r_dq[VAR_W-1:0]);
                r_root <= '0;
                r_srem <= '0;
            end
            OP_SQRT_STEP: begin
                if (s_cand >= (SR_W+2)'(s_trial)) begin
                    r_srem <= SR_W'(s_cand - (SR_W+2)'(s_trial));
                    r_root <= {r_root[SE_W-2:0], 1'b1};
                end else begin
                    r_srem <= SR_W'(s_cand);
                    r_root <= {r_root[SE_W-2:0], 1'b0};
                end
                r_sv <= r_sv << 2;
            end
            OP_MARGIN_LD: begin
                r_se <= r_root;
                r_dq <= WIDE_W'(se_scaled);
            end
            OP_MEAN_LD: begin
                r_margin <= margin_prod[CI_DEN_SHIFT +: CI_W];
                r_dq     <= WIDE_W'(sum_mag);
                r_drem   <= '0;
                r_dd     <= DIVR_W'(r_n);
            end
            OP_FINISH: begin
                o_count <= CNT_OUT_W'(r_n);
                o_stat  <= r_stat;
                if (r_special) begin
                    o_mean  <= '0;
                    o_var   <= '0;
                    o_se    <= '0;
                    o_ci_lo <= '0;
                    o_ci_hi <= '0;
                end else begin
                    o_mean  <= mean;
                    o_var   <= r_var;
                    o_se    <= r_se;
                    o_ci_lo <= lo_s;
                    o_ci_hi <= hi_s;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

### design/sample_mean_variance_ci.sv
// Top level: streaming sample mean, unbiased variance, standard error and 95% bounds.
// Samples are taken one beat per cycle while a set is open; no result is produced per sample.
// After the closing beat the block takes no beats until its result is loaded (an empty or
// single-value set skips the arithmetic): multiplier 2 x 40, divider 3 x 80, root 24 steps,
// each after a load state; longer while an earlier result waits unread in the output register.
// Reset (synchronous, active low) clears the accumulators, the mode register and output valid.
`default_nettype none
module sample_mean_variance_ci #(
    parameter int MAX_SAMPLES = smvci_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = smvci_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Configuration: antithetic mode bit.
    input  wire                                 i_cfg_wr_en,
    input  wire                                 i_cfg_wr_data,
    // Sample stream.
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [smvci_pkg::SAMPLE_W-1:0]      s_axis_tdata,  // [23:0] sample_value
    input  wire                                 s_axis_tlast,  // last_sample
    // Result stream.
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // [23:0] mean_value, [70:24] variance_value, [94:71] standard_error,
    // [120:95] ci_lower, [146:121] ci_upper, [161:147] sample_count, [167:162] zero
    output logic [smvci_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic [smvci_pkg::STAT_W-1:0]        m_axis_tuser   // [1:0] status_code
);
    import smvci_pkg::*;

    t_cmd    cmd;
    t_status status;

    logic [SAMPLE_W-1:0]  mean;
    logic [VAR_W-1:0]     var_v;
    logic [SE_W-1:0]      se;
    logic [CI_W-1:0]      ci_lo, ci_hi;
    logic [CNT_OUT_W-1:0] count;

    // The controller steps through accumulation and the end-of-set phases; every
    // arithmetic register lives in the datapath, which only follows the command code.
    smvci_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    smvci_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_sample      (s_axis_tdata),
        .o_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_mean        (mean),
        .o_var         (var_v),
        .o_se          (se),
        .o_ci_lo       (ci_lo),
        .o_ci_hi       (ci_hi),
        .o_count       (count),
        .o_stat        (m_axis_tuser)
    );

    // The result beat is packed from the lowest field up, padded to whole bytes.
    assign m_axis_tdata = OUT_DATA_W'({count, ci_hi, ci_lo, se, var_v, mean});

endmodule
`default_nettype wire
